[hdl/ucs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ucs_pkg;

   // Number of cells in the lookup chain and default table size.
   localparam int NUM_CELLS             = 8;
   localparam int TABLE_ENTRIES_DEFAULT = 1024;
   localparam int CP_W                  = 21;

   // Special characters and code points.
   localparam logic [7:0]      LBRACKET       = 8'h5B;
   localparam logic [7:0]      RBRACKET       = 8'h5D;
   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

   typedef struct packed {
      logic            mode;
      logic [7:0]      text_byte;
      logic            end_of_text;
      logic [9:0]      entry_index;
      logic [CP_W-1:0] entry_key;
      logic [CP_W-1:0] entry_value;
      logic            entry_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       text_done;
   } rsp_type;

   // One stored table entry.
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] key;
      logic [CP_W-1:0] value;
   } entry_type;

   // Match result handed from cell to cell.
   typedef struct packed {
      logic            hit;
      logic [CP_W-1:0] value;
   } match_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } enc_type;

   // Shortest UTF-8 form of a code point.
   function automatic enc_type encode_cp(input logic [CP_W-1:0] cp);
      enc_type e;
      e = '0;
      if (cp < 21'h80) begin
         e.bytes[0] = {1'b0, cp[6:0]};
         e.len      = 3'd1;
      end else if (cp < 21'h800) begin
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
         e.len      = 3'd2;
      end else if (cp < 21'h10000) begin
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
         e.len      = 3'd3;
      end else begin
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
         e.len      = 3'd4;
      end
      return e;
   endfunction

endpackage

`default_nettype wire

[hdl/utf8_codepoint_substituter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | req_type
// rsp     | out       | rsp_valid / rsp_ready | rsp_type
//
// After reset a clearing pass over the DEPTH slice addresses (128 at 1024 entries) empties the table.
// A table write, or a byte that yields neither a code point nor a raw byte, leaves the block idle.
// A code point lookup scans all cells in parallel over the slice depth, then the result
// passes down the cell chain; output bytes then follow one per cycle while rsp_ready is high.
// Output bytes are held stable while rsp_ready is low; no new item is taken meanwhile.
module utf8_codepoint_substituter
   import ucs_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   localparam int SLICE     = (TABLE_ENTRIES + NUM_CELLS - 1) / NUM_CELLS;
   localparam int LOG_DEPTH = $clog2(SLICE);
   localparam int DEPTH     = 1 << LOG_DEPTH;
   localparam int ADDR_W    = (LOG_DEPTH > 0) ? LOG_DEPTH : 1;
   localparam int SCAN_LAST = DEPTH + NUM_CELLS + 2;
   localparam int CNT_W     = $clog2(SCAN_LAST + 2);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             tag_ff, tag_in;
   logic [CP_W-1:0]  part_ff, part_in;
   logic [1:0]       rem_ff, rem_in;
   logic [CP_W-1:0]  cp_ff;
   logic             has_raw_ff;
   logic [7:0]       raw_ff;
   logic             eot_ff;
   logic [7:0]       obuf_ff [5];
   logic [2:0]       ocnt_ff;
   logic [2:0]       optr_ff;

   logic             req_xfer, rsp_xfer, last;
   logic             dec_has_cp, dec_has_raw;
   logic [CP_W-1:0]  dec_cp, merged;
   logic [CP_W-1:0]  sub_cp;
   enc_type          enc;
   logic [16:0]      idx;
   logic             wr_any;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic             scan_done;
   match_type        chain [NUM_CELLS+1];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_xfer  = rsp_valid && rsp_ready;
   assign last      = (optr_ff == ocnt_ff - 3'd1);
   assign scan_done = (state_ff == ST_SCAN) && (cnt_ff == CNT_W'(SCAN_LAST));

   // Text decoding: one step of the lead-byte state machine per byte.
   always_comb begin
      tag_in      = tag_ff;
      part_in     = part_ff;
      rem_in      = rem_ff;
      dec_has_cp  = 1'b0;
      dec_has_raw = 1'b0;
      dec_cp      = '0;
      unique case (rem_ff)
         2'd3:    merged = part_ff | {3'd0, req.text_byte[5:0], 12'd0};
         2'd2:    merged = part_ff | {9'd0, req.text_byte[5:0], 6'd0};
         default: merged = part_ff | {15'd0, req.text_byte[5:0]};
      endcase
      if (tag_ff) begin
         dec_has_raw = 1'b1;
         if (req.text_byte == RBRACKET) begin
            tag_in = 1'b0;
         end
      end else if (req.text_byte == LBRACKET) begin
         if (rem_ff != 2'd0) begin
            dec_has_cp = 1'b1;
            dec_cp     = part_ff;
            rem_in     = 2'd0;
            part_in    = '0;
         end
         dec_has_raw = 1'b1;
         tag_in      = 1'b1;
      end else if (rem_ff != 2'd0) begin
         rem_in = rem_ff - 2'd1;
         if (rem_ff == 2'd1) begin
            dec_has_cp = 1'b1;
            dec_cp     = merged;
            part_in    = '0;
         end else begin
            part_in = merged;
         end
      end else if (req.text_byte < 8'h80) begin
         dec_has_cp = 1'b1;
         dec_cp     = {14'd0, req.text_byte[6:0]};
      end else if ((req.text_byte & 8'hE0) == 8'hC0) begin
         part_in = {10'd0, req.text_byte[4:0], 6'd0};
         rem_in  = 2'd1;
      end else if ((req.text_byte & 8'hF0) == 8'hE0) begin
         part_in = {5'd0, req.text_byte[3:0], 12'd0};
         rem_in  = 2'd2;
      end else if ((req.text_byte & 8'hF8) == 8'hF0) begin
         part_in = {req.text_byte[2:0], 18'd0};
         rem_in  = 2'd3;
      end else begin
         dec_has_cp = 1'b1;
         dec_cp     = REPLACEMENT_CP;
      end
      // End of text completes any open sequence with zero bits.
      if (req.end_of_text) begin
         if (rem_in != 2'd0) begin
            dec_has_cp = 1'b1;
            dec_cp     = part_in;
         end
         tag_in  = 1'b0;
         part_in = '0;
         rem_in  = 2'd0;
      end
   end

   // Controller sequencing.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer && !req.mode) begin
               if (dec_has_cp) begin
                  state_in = ST_SCAN;
               end else if (dec_has_raw) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (scan_done) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer && last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         tag_ff   <= 1'b0;
         part_ff  <= '0;
         rem_ff   <= 2'd0;
         optr_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (req_xfer && !req.mode) begin
            tag_ff  <= tag_in;
            part_ff <= part_in;
            rem_ff  <= rem_in;
         end
         if (rsp_xfer) begin
            optr_ff <= last ? 3'd0 : optr_ff + 3'd1;
         end
      end
   end

   // Result encoding into the output byte buffer.
   assign sub_cp = chain[0].hit ? chain[0].value : cp_ff;
   always_comb begin
      enc = encode_cp(sub_cp);
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !req.mode) begin
         cp_ff      <= dec_cp;
         has_raw_ff <= dec_has_raw;
         raw_ff     <= req.text_byte;
         eot_ff     <= req.end_of_text;
         if (!dec_has_cp) begin
            obuf_ff[0] <= req.text_byte;
            ocnt_ff    <= 3'd1;
         end
      end
      if (scan_done) begin
         // The raw byte, when there is one, follows the encoded bytes.
         for (int k = 0; k < 4; k++) begin
            obuf_ff[k] <= (has_raw_ff && (enc.len == 3'(k))) ? raw_ff : enc.bytes[k];
         end
         obuf_ff[4] <= raw_ff;
         ocnt_ff    <= enc.len + {2'd0, has_raw_ff};
      end
   end

   assign rsp.out_byte    = obuf_ff[optr_ff];
   assign rsp.last_of_run = last;
   assign rsp.text_done   = last && eot_ff;

   // Table write and clearing-pass port shared by all cells.
   assign idx      = 17'(req.entry_index);
   assign wr_any   = req_xfer && req.mode && (idx < 17'(TABLE_ENTRIES));
   assign wr_addr  = (state_ff == ST_CLEAR) ? cnt_ff[ADDR_W-1:0]
                                            : ADDR_W'(idx & 17'(DEPTH - 1));
   assign wr_entry = (state_ff == ST_CLEAR) ? '0
                   : '{valid: req.entry_valid, key: req.entry_key, value: req.entry_value};
   assign rd_en    = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(DEPTH));
   assign rd_addr  = cnt_ff[ADDR_W-1:0];

   assign chain[NUM_CELLS] = '0;

   // Chain of table slices; cell 0 holds the lowest indices.
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      logic cell_we;
      assign cell_we = (state_ff == ST_CLEAR)
                    || (wr_any && ((idx >> LOG_DEPTH) == 17'(i)));
      ucs_cell #(
         .DEPTH  (DEPTH),
         .ADDR_W (ADDR_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .wr_en        (cell_we),
         .wr_addr      (wr_addr),
         .wr_entry     (wr_entry),
         .rd_en        (rd_en),
         .rd_addr      (rd_addr),
         .search_start (req_xfer),
         .search_key   (cp_ff),
         .chain_in     (chain[i+1]),
         .chain_out    (chain[i])
      );
   end

   // A tag never coexists with an open multibyte sequence.
   a_tag_no_partial: assert property (@(posedge clock) disable iff (reset)
      tag_ff |-> (rem_ff == 2'd0))
      else $error("open sequence inside a tag");

   // The emit pointer stays within the filled part of the buffer.
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (optr_ff < ocnt_ff) && (ocnt_ff != 3'd0))
      else $error("emit pointer out of range");

   // The last byte of a run hands control back for the next item.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && last |=> (state_ff == ST_IDLE) && (optr_ff == 3'd0))
      else $error("run did not end after its last byte");

   // An item that opens a lookup never shows a result in the next cycle.
   a_scan_delay: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && req_xfer && !req.mode && dec_has_cp |=> !rsp_valid)
      else $error("result before lookup finished");

endmodule

`default_nettype wire

[hdl/ucs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ucs_cell
   import ucs_pkg::*;
#(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_entry,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic              search_start,
   input  wire logic [CP_W-1:0]   search_key,
   input  wire match_type         chain_in,
   output match_type              chain_out
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   logic      rd_vld_ff;
   logic      found_ff;
   logic [CP_W-1:0] found_val_ff;
   match_type chain_ff;
   logic      match;

   // Slice memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign match = rd_vld_ff && rd_data_ff.valid && (rd_data_ff.key == search_key);

   // The first hit in address order is the lowest index in this slice.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (search_start) begin
            found_ff <= 1'b0;
         end else if (match && !found_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (match && !found_ff) begin
         found_val_ff <= rd_data_ff.value;
      end
   end

   // A hit here overrides anything coming from higher slices.
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else if (found_ff) begin
         chain_ff <= '{hit: 1'b1, value: found_val_ff};
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain_out = chain_ff;

endmodule

`default_nettype wire
